// ===== src/uwbls_pkg.sv =====
package uwbls_pkg;

  // Field widths of the item and result channels.
  localparam int unsigned KIND_W      = 3;
  localparam int unsigned SEQ_W       = 32;
  localparam int unsigned LEN_W       = 10;
  localparam int unsigned POWER_W     = 32;
  localparam int unsigned QUAL_W      = 16;
  localparam int unsigned FPRAW_W     = 16;
  localparam int unsigned FP_FRAC     = 6;
  localparam int unsigned FP_W        = FPRAW_W - FP_FRAC;
  localparam int unsigned STAT_ID_W   = 4;
  localparam int unsigned STAT_VAL_W  = 33;

  // Statistics state widths.
  localparam int unsigned CNT_W       = 32;
  localparam int unsigned RSSI_W      = 8;
  localparam int unsigned RSSI_SUM_W  = 40;
  localparam int unsigned QUAL_SUM_W  = 48;
  localparam int unsigned FP_SUM_W    = 42;

  // Shared divider operand widths.
  localparam int unsigned DIVIDEND_W  = 48;
  localparam int unsigned DIVISOR_W   = CNT_W;

  localparam logic [LEN_W-1:0] MAX_LEN_RESET = LEN_W'(127);

  // RSSI mapping: (power >> 16) - 100, capped at 0; zero power maps to -128.
  localparam int unsigned POWER_SHIFT = 16;
  localparam logic [POWER_W-POWER_SHIFT-1:0] RSSI_OFFSET = 16'd100;
  localparam logic signed [RSSI_W-1:0] RSSI_FLOOR = -8'sd128;

  typedef enum logic [KIND_W-1:0] {
    KIND_STATUS = 3'd0,
    KIND_QUERY  = 3'd1,
    KIND_CLEAR  = 3'd2,
    KIND_START  = 3'd3,
    KIND_STOP   = 3'd4
  } kind_e;

  localparam logic [STAT_ID_W-1:0] STAT_RX       = 4'd0;
  localparam logic [STAT_ID_W-1:0] STAT_LOST     = 4'd1;
  localparam logic [STAT_ID_W-1:0] STAT_CRC      = 4'd2;
  localparam logic [STAT_ID_W-1:0] STAT_PHY      = 4'd3;
  localparam logic [STAT_ID_W-1:0] STAT_TIMEOUT  = 4'd4;
  localparam logic [STAT_ID_W-1:0] STAT_OVERRUN  = 4'd5;
  localparam logic [STAT_ID_W-1:0] STAT_RSSI_AVG = 4'd6;
  localparam logic [STAT_ID_W-1:0] STAT_RSSI_MIN = 4'd7;
  localparam logic [STAT_ID_W-1:0] STAT_RSSI_MAX = 4'd8;
  localparam logic [STAT_ID_W-1:0] STAT_QUAL_AVG = 4'd9;
  localparam logic [STAT_ID_W-1:0] STAT_QUAL_MIN = 4'd10;
  localparam logic [STAT_ID_W-1:0] STAT_QUAL_MAX = 4'd11;
  localparam logic [STAT_ID_W-1:0] STAT_FP_AVG   = 4'd12;
  localparam logic [STAT_ID_W-1:0] STAT_LAST     = STAT_FP_AVG;

  // Which average the shared divider is working on.
  localparam logic [1:0] AVG_RSSI = 2'd0;
  localparam logic [1:0] AVG_QUAL = 2'd1;
  localparam logic [1:0] AVG_FP   = 2'd2;

endpackage

// ===== src/uwb_rx_link_statistics_unit.sv =====
// A receive status, clear, start or stop item is accepted, then applied in the update state.
// A query with samples first computes three averages, one after another through a
// single 48-step divider, then streams its 13 statistics.
// A query with no samples starts its 13 transfers straight after the update state.
// Throughput: one item at a time; input stall stays high until the item is done.
// Reset (rst_ni low, asynchronous): all statistics zero, not running, max length 127.
module uwb_rx_link_statistics_unit (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // Configuration: max_frame_len.
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [uwbls_pkg::LEN_W-1:0]            cfg_data_i,
  // Item channel.
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic [uwbls_pkg::KIND_W-1:0]           kind_i,
  input  logic [uwbls_pkg::SEQ_W-1:0]            seq_i,
  input  logic [uwbls_pkg::LEN_W-1:0]            frame_len_i,
  input  logic [uwbls_pkg::POWER_W-1:0]          chan_power_i,
  input  logic [uwbls_pkg::QUAL_W-1:0]           accum_count_i,
  input  logic [uwbls_pkg::FPRAW_W-1:0]          fp_index_raw_i,
  input  logic                                   good_frame_i,
  input  logic                                   crc_error_i,
  input  logic                                   phy_error_i,
  input  logic                                   rx_timeout_i,
  input  logic                                   rx_overrun_i,
  // Result channel.
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic [uwbls_pkg::STAT_ID_W-1:0]        stat_id_o,
  output logic signed [uwbls_pkg::STAT_VAL_W-1:0] stat_value_o,
  output logic                                   last_o
);

  import uwbls_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_DIV_LOAD,
    S_DIV_WAIT,
    S_EMIT
  } state_e;

  state_e state_q;

  // The item is captured on acceptance and worked on from these registers.
  logic [KIND_W-1:0]  kind_q;
  logic [SEQ_W-1:0]   seq_q;
  logic [LEN_W-1:0]   frame_len_q;
  logic [POWER_W-1:0] power_q;
  logic [QUAL_W-1:0]  qual_q;
  logic [FP_W-1:0]    fp_q;
  logic               good_q, crc_q, phy_q, tmo_q, ovr_q;

  logic [LEN_W-1:0]   max_len_q;

  // Statistics. The received count and the sample count step together and
  // clear together, so a single counter serves both.
  logic                         running_q;
  logic [CNT_W-1:0]             rx_cnt_q, lost_cnt_q, crc_cnt_q, phy_cnt_q;
  logic [CNT_W-1:0]             tmo_cnt_q, ovr_cnt_q;
  logic [SEQ_W-1:0]             next_seq_q;
  logic                         seq_seen_q;
  logic [RSSI_SUM_W-1:0]        rssi_acc_q;
  logic [QUAL_SUM_W-1:0]        qual_sum_q;
  logic [FP_SUM_W-1:0]          fp_sum_q;
  logic signed [RSSI_W-1:0]     rssi_lo_q, rssi_hi_q;
  logic [QUAL_W-1:0]            qual_lo_q, qual_hi_q;

  // Averages produced by the divider for the query in progress.
  logic [STAT_VAL_W-1:0]        ravg_q, qavg_q, favg_q;
  logic [1:0]                   avg_sel_q;
  logic [STAT_ID_W-1:0]         emit_idx_q;

  logic                         out_valid_q, last_q;
  logic [STAT_ID_W-1:0]         stat_id_q;
  logic [STAT_VAL_W-1:0]        stat_val_q;

  logic                         accept;
  logic                         exec_status, exec_clear, exec_start, exec_stop;
  logic                         out_free;

  assign accept      = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o  = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || !out_stall_i;

  // Decode of the captured kind; unused kinds fall through and do nothing.
  always_comb begin
    exec_status = 1'b0;
    exec_clear  = 1'b0;
    exec_start  = 1'b0;
    exec_stop   = 1'b0;
    if (state_q == S_EXEC) begin
      unique case (kind_e'(kind_q))
        KIND_STATUS: exec_status = running_q;
        KIND_CLEAR:  exec_clear  = 1'b1;
        KIND_START:  exec_start  = 1'b1;
        KIND_STOP:   exec_stop   = 1'b1;
        default:     ;
      endcase
    end
  end

  // RSSI of the captured frame. Below the offset the difference lies in
  // -100..-1, so only the floor for zero power and the ceiling at zero remain.
  logic [POWER_W-POWER_SHIFT-1:0] power_hi;
  logic signed [RSSI_W-1:0]       rssi;

  always_comb begin
    power_hi = power_q[POWER_W-1:POWER_SHIFT];
    if (power_q == '0) begin
      rssi = RSSI_FLOOR;
    end else if (power_hi >= RSSI_OFFSET) begin
      rssi = '0;
    end else begin
      rssi = power_hi[RSSI_W-1:0] - RSSI_OFFSET[RSSI_W-1:0];
    end
  end

  // A good frame within the length limit counts; error flags are ignored then.
  logic             count_frame, first_sample, seq_gap;
  logic [SEQ_W-1:0] gap;

  assign count_frame  = exec_status && good_q && (frame_len_q <= max_len_q);
  assign first_sample = (rx_cnt_q == '0);
  assign gap          = seq_q - next_seq_q;
  assign seq_gap      = seq_seen_q && (seq_q > next_seq_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MAX_LEN_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      max_len_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q      <= kind_i;
      seq_q       <= seq_i;
      frame_len_q <= frame_len_i;
      power_q     <= chan_power_i;
      qual_q      <= accum_count_i;
      fp_q        <= fp_index_raw_i[FPRAW_W-1:FP_FRAC];
      good_q      <= good_frame_i;
      crc_q       <= crc_error_i;
      phy_q       <= phy_error_i;
      tmo_q       <= rx_timeout_i;
      ovr_q       <= rx_overrun_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q  <= 1'b0;
      rx_cnt_q   <= '0;
      lost_cnt_q <= '0;
      crc_cnt_q  <= '0;
      phy_cnt_q  <= '0;
      tmo_cnt_q  <= '0;
      ovr_cnt_q  <= '0;
      next_seq_q <= '0;
      seq_seen_q <= 1'b0;
      rssi_acc_q <= '0;
      qual_sum_q <= '0;
      fp_sum_q   <= '0;
      rssi_lo_q  <= '0;
      rssi_hi_q  <= '0;
      qual_lo_q  <= '0;
      qual_hi_q  <= '0;
    end else begin
      if (exec_clear || exec_start) begin
        rx_cnt_q   <= '0;
        lost_cnt_q <= '0;
        crc_cnt_q  <= '0;
        phy_cnt_q  <= '0;
        tmo_cnt_q  <= '0;
        ovr_cnt_q  <= '0;
        next_seq_q <= '0;
        seq_seen_q <= 1'b0;
        rssi_acc_q <= '0;
        qual_sum_q <= '0;
        fp_sum_q   <= '0;
        rssi_lo_q  <= '0;
        rssi_hi_q  <= '0;
        qual_lo_q  <= '0;
        qual_hi_q  <= '0;
      end
      if (exec_start) begin
        running_q <= 1'b1;
      end
      if (exec_stop) begin
        running_q <= 1'b0;
      end
      if (count_frame) begin
        rx_cnt_q   <= rx_cnt_q + CNT_W'(1);
        if (seq_gap) begin
          lost_cnt_q <= lost_cnt_q + gap;
        end
        seq_seen_q <= 1'b1;
        next_seq_q <= seq_q + SEQ_W'(1);
        rssi_acc_q <= rssi_acc_q + {{(RSSI_SUM_W-RSSI_W){rssi[RSSI_W-1]}}, rssi};
        qual_sum_q <= qual_sum_q + {{(QUAL_SUM_W-QUAL_W){1'b0}}, qual_q};
        fp_sum_q   <= fp_sum_q + {{(FP_SUM_W-FP_W){1'b0}}, fp_q};
        if (first_sample) begin
          rssi_lo_q <= rssi;
          rssi_hi_q <= rssi;
          qual_lo_q <= qual_q;
          qual_hi_q <= qual_q;
        end else begin
          if (rssi < rssi_lo_q) rssi_lo_q <= rssi;
          if (rssi > rssi_hi_q) rssi_hi_q <= rssi;
          if (qual_q < qual_lo_q) qual_lo_q <= qual_q;
          if (qual_q > qual_hi_q) qual_hi_q <= qual_q;
        end
      end else if (exec_status && !good_q) begin
        if (crc_q) crc_cnt_q <= crc_cnt_q + CNT_W'(1);
        if (phy_q) phy_cnt_q <= phy_cnt_q + CNT_W'(1);
        if (tmo_q) tmo_cnt_q <= tmo_cnt_q + CNT_W'(1);
        if (ovr_q) ovr_cnt_q <= ovr_cnt_q + CNT_W'(1);
      end
    end
  end

  // The RSSI sum is signed: its magnitude is divided and the quotient
  // negated afterwards, which truncates toward zero.
  logic                  rssi_neg;
  logic [RSSI_SUM_W-1:0] rssi_mag;
  logic [DIVIDEND_W-1:0] dividend;
  logic [DIVIDEND_W-1:0] quotient;
  logic [STAT_VAL_W-1:0] quo_low;
  logic                  div_start, div_done;

  assign rssi_neg  = rssi_acc_q[RSSI_SUM_W-1];
  assign rssi_mag  = rssi_neg ? (RSSI_SUM_W'(0) - rssi_acc_q) : rssi_acc_q;
  assign quo_low   = quotient[STAT_VAL_W-1:0];
  assign div_start = (state_q == S_DIV_LOAD);

  always_comb begin
    unique case (avg_sel_q)
      AVG_RSSI: dividend = {{(DIVIDEND_W-RSSI_SUM_W){1'b0}}, rssi_mag};
      AVG_QUAL: dividend = qual_sum_q;
      default:  dividend = {{(DIVIDEND_W-FP_SUM_W){1'b0}}, fp_sum_q};
    endcase
  end

  uwbls_div #(
    .DividendW (DIVIDEND_W),
    .DivisorW  (DIVISOR_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (rx_cnt_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // Value of the statistic selected by the emit index.
  logic [STAT_VAL_W-1:0] emit_val;

  always_comb begin
    unique case (emit_idx_q)
      STAT_RX:       emit_val = {1'b0, rx_cnt_q};
      STAT_LOST:     emit_val = {1'b0, lost_cnt_q};
      STAT_CRC:      emit_val = {1'b0, crc_cnt_q};
      STAT_PHY:      emit_val = {1'b0, phy_cnt_q};
      STAT_TIMEOUT:  emit_val = {1'b0, tmo_cnt_q};
      STAT_OVERRUN:  emit_val = {1'b0, ovr_cnt_q};
      STAT_RSSI_AVG: emit_val = ravg_q;
      STAT_RSSI_MIN: emit_val = {{(STAT_VAL_W-RSSI_W){rssi_lo_q[RSSI_W-1]}}, rssi_lo_q};
      STAT_RSSI_MAX: emit_val = {{(STAT_VAL_W-RSSI_W){rssi_hi_q[RSSI_W-1]}}, rssi_hi_q};
      STAT_QUAL_AVG: emit_val = qavg_q;
      STAT_QUAL_MIN: emit_val = {{(STAT_VAL_W-QUAL_W){1'b0}}, qual_lo_q};
      STAT_QUAL_MAX: emit_val = {{(STAT_VAL_W-QUAL_W){1'b0}}, qual_hi_q};
      default:       emit_val = favg_q;
    endcase
  end

  // Sequencer: takes an item, runs the divider three times for a query
  // with samples, then streams the 13 statistics through the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      avg_sel_q   <= AVG_RSSI;
      emit_idx_q  <= STAT_RX;
      out_valid_q <= 1'b0;
      last_q      <= 1'b0;
      stat_id_q   <= STAT_RX;
      stat_val_q  <= '0;
      ravg_q      <= '0;
      qavg_q      <= '0;
      favg_q      <= '0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (kind_e'(kind_q) == KIND_QUERY) begin
            emit_idx_q <= STAT_RX;
            avg_sel_q  <= AVG_RSSI;
            if (rx_cnt_q == '0) begin
              ravg_q  <= '0;
              qavg_q  <= '0;
              favg_q  <= '0;
              state_q <= S_EMIT;
            end else begin
              state_q <= S_DIV_LOAD;
            end
          end else begin
            state_q <= S_IDLE;
          end
        end
        S_DIV_LOAD: begin
          state_q <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (div_done) begin
            unique case (avg_sel_q)
              AVG_RSSI: ravg_q <= rssi_neg ? (STAT_VAL_W'(0) - quo_low) : quo_low;
              AVG_QUAL: qavg_q <= quo_low;
              default:  favg_q <= quo_low;
            endcase
            if (avg_sel_q == AVG_FP) begin
              state_q <= S_EMIT;
            end else begin
              avg_sel_q <= avg_sel_q + 2'd1;
              state_q   <= S_DIV_LOAD;
            end
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            stat_id_q   <= emit_idx_q;
            stat_val_q  <= emit_val;
            last_q      <= (emit_idx_q == STAT_LAST);
            if (emit_idx_q == STAT_LAST) begin
              state_q <= S_IDLE;
            end else begin
              emit_idx_q <= emit_idx_q + STAT_ID_W'(1);
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign stat_id_o    = stat_id_q;
  assign stat_value_o = stat_val_q;
  assign last_o       = last_q;

endmodule

// ===== src/uwbls_div.sv =====
module uwbls_div #(
  parameter int unsigned DividendW = uwbls_pkg::DIVIDEND_W,
  parameter int unsigned DivisorW  = uwbls_pkg::DIVISOR_W
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [DividendW-1:0] dividend_i,
  input  logic [DivisorW-1:0]  divisor_i,
  output logic                 done_o,
  output logic [DividendW-1:0] quotient_o
);

  localparam int unsigned CntW = $clog2(DividendW);

  logic [DivisorW-1:0]  rem_q, rem_d;
  logic [DividendW-1:0] quo_q, quo_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DivisorW:0]    rem_sh;
  logic [DivisorW+1:0]  diff;
  logic                 fits;

  // Restoring division, one quotient bit per cycle; the quotient shifts in
  // where the dividend bits shift out.
  always_comb begin
    rem_sh = {rem_q, quo_q[DividendW-1]};
    diff   = {1'b0, rem_sh} - {2'b00, divisor_i};
    fits   = ~diff[DivisorW+1];
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = fits ? diff[DivisorW-1:0] : rem_sh[DivisorW-1:0];
      quo_d = {quo_q[DividendW-2:0], fits};
      cnt_d = cnt_q + CntW'(1);
      if (cnt_q == CntW'(DividendW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ===== src/uwbls_chk.sv =====
module uwbls_chk (
  input logic                                    clk_i,
  input logic                                    rst_ni,
  input logic                                    cfg_valid_i,
  input logic                                    cfg_ready_o,
  input logic [uwbls_pkg::LEN_W-1:0]             cfg_data_i,
  input logic                                    in_valid_i,
  input logic                                    in_stall_o,
  input logic [uwbls_pkg::KIND_W-1:0]            kind_i,
  input logic [uwbls_pkg::SEQ_W-1:0]             seq_i,
  input logic [uwbls_pkg::LEN_W-1:0]             frame_len_i,
  input logic [uwbls_pkg::POWER_W-1:0]           chan_power_i,
  input logic [uwbls_pkg::QUAL_W-1:0]            accum_count_i,
  input logic [uwbls_pkg::FPRAW_W-1:0]           fp_index_raw_i,
  input logic                                    good_frame_i,
  input logic                                    crc_error_i,
  input logic                                    phy_error_i,
  input logic                                    rx_timeout_i,
  input logic                                    rx_overrun_i,
  input logic                                    out_valid_o,
  input logic                                    out_stall_i,
  input logic [uwbls_pkg::STAT_ID_W-1:0]         stat_id_o,
  input logic signed [uwbls_pkg::STAT_VAL_W-1:0] stat_value_o,
  input logic                                    last_o
);

  import uwbls_pkg::*;

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(stat_id_o) && $stable(stat_value_o))
    else $error("stalled result changed");

  // Last is flagged on the final statistic only.
  a_last_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_o == (stat_id_o == STAT_LAST)))
    else $error("last flag does not match statistic id");

  // While a query is still streaming, no new item is taken.
  a_busy_stream: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> in_stall_o)
    else $error("item taken during a query stream");

  // Statistics of a query follow one another in id order without gaps.
  a_id_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_o
      |=> out_valid_o && (stat_id_o == $past(stat_id_o) + STAT_ID_W'(1)))
    else $error("statistic id sequence broken");

  // Every accepted item stalls the input in the cycle after it is taken.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("item accepted without update cycle");

endmodule

bind uwb_rx_link_statistics_unit uwbls_chk u_uwbls_chk (.*);
